// ===== design/csfp_pkg.sv =====
// Shared types and constants for the clock synthesizer frequency planner.
package csfp_pkg;

    localparam int FreqW     = 28;
    localparam int XtalW     = 26;
    localparam int DivNumW   = 46;
    localparam int DivDenW   = 28;
    localparam int DivCntW   = 6;
    localparam int IdxW      = 5;

    localparam logic [FreqW-1:0]   MinFreq    = 28'd7813;
    localparam logic [FreqW-1:0]   MaxFreq    = 28'd225000000;
    localparam logic [FreqW-1:0]   OneMhz     = 28'd1000000;
    localparam logic [XtalW-1:0]   XtalMin    = 26'd10000000;
    localparam logic [XtalW-1:0]   XtalReset  = 26'd27000000;
    localparam logic [DivNumW-1:0] VcoMaxHz   = 46'd900000000;
    localparam logic [19:0]        FracDenom  = 20'd1048575;
    localparam logic [7:0]         PllResetReg = 8'd177;
    localparam logic [IdxW-1:0]    LastIdx    = 5'd17;

    typedef struct packed {
        logic             chan_b;
        logic             zero;
        logic [FreqW-1:0] freq;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef struct packed {
        logic               start;
        logic [DivNumW-1:0] dividend;
        logic [DivDenW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DivNumW-1:0] quotient;
        logic [DivDenW-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOUBLE,
        ST_DIV_VCO,
        ST_MUL,
        ST_DIV_PLL,
        ST_MUL_NUM,
        ST_DIV_NUM,
        ST_EMIT
    } state_t;

endpackage

// ===== design/csfp_front.sv =====
// Front end: accepts requests, classifies them and clamps the frequency.
module csfp_front (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,    // command, freq_hz
    input  csfp_pkg::fifo_status_t      status,
    output logic                        push,
    output csfp_pkg::item_t             item
);
    logic [csfp_pkg::FreqW-1:0] freq_in;

    assign freq_in  = s_tdata[csfp_pkg::FreqW:1];
    assign s_tready = !status.full;
    assign push     = s_tvalid && !status.full;

    always_comb
    begin
        item.chan_b = s_tdata[0];
        item.zero   = (freq_in == '0);
        if (freq_in < csfp_pkg::MinFreq)
        begin
            item.freq = csfp_pkg::MinFreq;
        end
        else if (freq_in > csfp_pkg::MaxFreq)
        begin
            item.freq = csfp_pkg::MaxFreq;
        end
        else
        begin
            item.freq = freq_in;
        end
    end
endmodule

// ===== design/csfp_fifo.sv =====
// Two-entry queue between the front end and the sequencer.
module csfp_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  csfp_pkg::item_t        wr_item,
    input  logic                   pop,
    output csfp_pkg::item_t        rd_item,
    output csfp_pkg::fifo_status_t status
);
    csfp_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign rd_item      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end
endmodule

// ===== design/csfp_div.sv =====
// Restoring divider producing one quotient bit per cycle.
module csfp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  csfp_pkg::div_req_t  req,
    output csfp_pkg::div_rsp_t  rsp
);
    logic                          busy_reg, busy_next;
    logic [csfp_pkg::DivCntW-1:0]  cnt_reg, cnt_next;
    logic [csfp_pkg::DivNumW-1:0]  quo_reg, quo_next;
    logic [csfp_pkg::DivDenW-1:0]  rem_reg, rem_next;
    logic [csfp_pkg::DivDenW-1:0]  den_reg, den_next;
    logic [csfp_pkg::DivDenW:0]    trial;
    logic                          fits;
    logic [csfp_pkg::DivNumW-1:0]  quo_step;
    logic [csfp_pkg::DivDenW-1:0]  rem_step;
    logic                          done;

    assign trial    = {rem_reg, quo_reg[csfp_pkg::DivNumW-1]};
    assign fits     = (trial >= {1'b0, den_reg});
    assign quo_step = {quo_reg[csfp_pkg::DivNumW-2:0], fits};
    assign rem_step = fits ? csfp_pkg::DivDenW'(trial - {1'b0, den_reg})
                           : trial[csfp_pkg::DivDenW-1:0];
    assign done     = busy_reg &&
                      (cnt_reg == csfp_pkg::DivCntW'(csfp_pkg::DivNumW - 1));

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done;
    assign rsp.quotient  = quo_step;
    assign rsp.remainder = rem_step;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = quo_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end
endmodule

// ===== design/csfp_back.sv =====
// Sequencer: computes the frequency plan and emits the register writes.
module csfp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [csfp_pkg::XtalW-1:0]  crystal_hz,
    input  csfp_pkg::fifo_status_t      status,
    input  csfp_pkg::item_t             item,
    output logic                        pop,
    output csfp_pkg::div_req_t          div_req,
    input  csfp_pkg::div_rsp_t          div_rsp,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [15:0]                 m_tdata,
    output logic                        m_tlast
);
    csfp_pkg::state_t               state_reg, state_next;
    logic                           chan_reg, chan_next;
    logic                           zero_reg, zero_next;
    logic [csfp_pkg::FreqW-1:0]     f_reg, f_next;
    logic [2:0]                     rdiv_reg, rdiv_next;
    logic [9:0]                     divider_reg, divider_next;
    logic [7:0]                     mult_reg, mult_next;
    logic [csfp_pkg::XtalW-1:0]     rem_reg, rem_next;
    logic [6:0]                     t_reg, t_next;
    logic [19:0]                    p2_reg, p2_next;
    logic [csfp_pkg::IdxW-1:0]      idx_reg, idx_next;
    logic                           ov_reg, ov_next;
    logic [7:0]                     oaddr_reg, oaddr_next;
    logic [7:0]                     odata_reg, odata_next;
    logic                           olast_reg, olast_next;

    logic [csfp_pkg::XtalW-1:0]     xtal;
    logic                           dbl;
    logic                           out_ok;
    logic [37:0]                    pll_prod;
    logic [45:0]                    num_prod;
    logic [17:0]                    pll_p1;
    logic [17:0]                    ms_p1;
    logic [7:0]                     pll_base, ms_base, ctrl_reg, byte_addr, byte_data;
    logic [19:0]                    num_q;
    logic [20:0]                    t_sum;
    logic                           t_carry;

    assign xtal     = (crystal_hz < csfp_pkg::XtalMin) ? csfp_pkg::XtalMin : crystal_hz;
    assign dbl      = chan_reg ? (f_reg <= csfp_pkg::OneMhz) : (f_reg < csfp_pkg::OneMhz);
    assign out_ok   = !ov_reg || m_tready;
    assign pll_prod = divider_reg * f_reg;
    assign num_prod = rem_reg * csfp_pkg::FracDenom;
    assign pll_p1   = {3'b000, mult_reg, 7'b0000000} + {11'd0, t_reg} - 18'd512;
    assign ms_p1    = {1'b0, divider_reg, 7'b0000000} - 18'd512;
    assign pll_base = chan_reg ? 8'd34 : 8'd26;
    assign ms_base  = chan_reg ? 8'd58 : 8'd42;
    assign ctrl_reg = chan_reg ? 8'd18 : 8'd16;

    // Division of 128 * num by 2^20 - 1: the high part plus one more when the folded low part
    // reaches the denominator; the folded sum less that correction is the remainder.
    assign num_q    = div_rsp.quotient[19:0];
    assign t_sum    = {1'b0, num_q[12:0], 7'b0000000} + {14'd0, num_q[19:13]};
    assign t_carry  = (t_sum >= {1'b0, csfp_pkg::FracDenom});

    assign m_tvalid = ov_reg;
    assign m_tdata  = {odata_reg, oaddr_reg};
    assign m_tlast  = olast_reg;

    always_comb
    begin
        byte_addr = pll_base + {3'b000, idx_reg};
        byte_data = 8'h00;
        unique case (idx_reg)
            5'd0, 5'd1: byte_data = 8'hFF;
            5'd2:  byte_data = {6'b0, pll_p1[17:16]};
            5'd3:  byte_data = pll_p1[15:8];
            5'd4:  byte_data = pll_p1[7:0];
            5'd5:  byte_data = {4'hF, p2_reg[19:16]};
            5'd6:  byte_data = p2_reg[15:8];
            5'd7:  byte_data = p2_reg[7:0];
            5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15:
            begin
                byte_addr = ms_base + {3'b000, idx_reg} - 8'd8;
                if (idx_reg == 5'd9)
                begin
                    byte_data = 8'h01;
                end
                else if (idx_reg == 5'd10)
                begin
                    byte_data = {1'b0, rdiv_reg, 2'b00, ms_p1[17:16]};
                end
                else if (idx_reg == 5'd11)
                begin
                    byte_data = ms_p1[15:8];
                end
                else if (idx_reg == 5'd12)
                begin
                    byte_data = ms_p1[7:0];
                end
            end
            5'd16:
            begin
                byte_addr = csfp_pkg::PllResetReg;
                byte_data = chan_reg ? 8'h80 : 8'h20;
            end
            default:
            begin
                byte_addr = ctrl_reg;
                byte_data = zero_reg ? 8'h80 : (chan_reg ? 8'h6C : 8'h4F);
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        chan_next    = chan_reg;
        zero_next    = zero_reg;
        f_next       = f_reg;
        rdiv_next    = rdiv_reg;
        divider_next = divider_reg;
        mult_next    = mult_reg;
        rem_next     = rem_reg;
        t_next       = t_reg;
        p2_next      = p2_reg;
        idx_next     = idx_reg;
        ov_next      = ov_reg && !m_tready;
        oaddr_next   = oaddr_reg;
        odata_next   = odata_reg;
        olast_next   = olast_reg;
        pop          = 1'b0;
        div_req      = '0;
        unique case (state_reg)
            csfp_pkg::ST_IDLE:
            begin
                if (!status.empty)
                begin
                    pop       = 1'b1;
                    chan_next = item.chan_b;
                    zero_next = item.zero;
                    f_next    = item.freq;
                    rdiv_next = 3'd0;
                    if (item.zero)
                    begin
                        idx_next   = csfp_pkg::LastIdx;
                        state_next = csfp_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = csfp_pkg::ST_DOUBLE;
                    end
                end
            end
            csfp_pkg::ST_DOUBLE:
            begin
                if (dbl)
                begin
                    f_next    = {f_reg[csfp_pkg::FreqW-2:0], 1'b0};
                    rdiv_next = rdiv_reg + 3'd1;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = csfp_pkg::VcoMaxHz;
                    div_req.divisor  = f_reg;
                    state_next       = csfp_pkg::ST_DIV_VCO;
                end
            end
            csfp_pkg::ST_DIV_VCO:
            begin
                if (div_rsp.done)
                begin
                    divider_next = {div_rsp.quotient[9:1], 1'b0};
                    state_next   = csfp_pkg::ST_MUL;
                end
            end
            csfp_pkg::ST_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {16'd0, pll_prod[29:0]};
                div_req.divisor  = {2'b00, xtal};
                state_next       = csfp_pkg::ST_DIV_PLL;
            end
            csfp_pkg::ST_DIV_PLL:
            begin
                if (div_rsp.done)
                begin
                    mult_next  = div_rsp.quotient[7:0];
                    rem_next   = div_rsp.remainder[csfp_pkg::XtalW-1:0];
                    state_next = csfp_pkg::ST_MUL_NUM;
                end
            end
            csfp_pkg::ST_MUL_NUM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = num_prod;
                div_req.divisor  = {2'b00, xtal};
                state_next       = csfp_pkg::ST_DIV_NUM;
            end
            csfp_pkg::ST_DIV_NUM:
            begin
                if (div_rsp.done)
                begin
                    t_next     = num_q[19:13] + {6'd0, t_carry};
                    p2_next    = t_carry ? 20'(t_sum - {1'b0, csfp_pkg::FracDenom})
                                         : t_sum[19:0];
                    idx_next   = '0;
                    state_next = csfp_pkg::ST_EMIT;
                end
            end
            default:
            begin
                if (out_ok)
                begin
                    ov_next    = 1'b1;
                    oaddr_next = byte_addr;
                    odata_next = byte_data;
                    olast_next = (idx_reg == csfp_pkg::LastIdx);
                    if (idx_reg == csfp_pkg::LastIdx)
                    begin
                        state_next = csfp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csfp_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg    <= chan_next;
        zero_reg    <= zero_next;
        f_reg       <= f_next;
        rdiv_reg    <= rdiv_next;
        divider_reg <= divider_next;
        mult_reg    <= mult_next;
        rem_reg     <= rem_next;
        t_reg       <= t_next;
        p2_reg      <= p2_next;
        oaddr_reg   <= oaddr_next;
        odata_reg   <= odata_next;
        olast_reg   <= olast_next;
    end
endmodule

// ===== design/clock_synth_frequency_planner.sv =====
// Top level of the clock synthesizer frequency planner.
// Each request transaction yields 18 register-write transactions, or one power-down write
// for a zero frequency. A request passes through the sequencer in order: it is taken from
// the queue, its frequency is doubled up to seven times, the divider is started, three passes
// run through the shared bit-serial divider with a multiply state before each of the last two,
// and the 18 writes are emitted. The crystal register must be written only while the block
// is idle.
module clock_synth_frequency_planner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [25:0] cfg_wdata,   // crystal_hz
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // command, freq_hz
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,     // reg_address, reg_data
    output logic        m_tlast
);
    logic [csfp_pkg::XtalW-1:0]  crystal_reg, crystal_next;
    logic                        push, pop;
    csfp_pkg::item_t             wr_item, rd_item;
    csfp_pkg::fifo_status_t      status;
    csfp_pkg::div_req_t          div_req;
    csfp_pkg::div_rsp_t          div_rsp;

    assign crystal_next = cfg_we ? cfg_wdata : crystal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crystal_reg <= csfp_pkg::XtalReset;
        end
        else
        begin
            crystal_reg <= crystal_next;
        end
    end

    csfp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .status   (status),
        .push     (push),
        .item     (wr_item)
    );

    csfp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .status  (status)
    );

    csfp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    csfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .crystal_hz (crystal_reg),
        .status     (status),
        .item       (rd_item),
        .pop        (pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("Queue read while empty.");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (!div_rsp.busy || div_rsp.done))
        else $error("Divider restarted in the middle of a division.");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |=> !div_rsp.busy || $past(div_req.start))
        else $error("Divider kept running after completion.");
`endif
endmodule

// ===== tb/clock_synth_frequency_planner_test.sv =====
// Self-checking testbench for the clock synthesizer frequency planner.
module clock_synth_frequency_planner_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } reg_write_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [25:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;

    reg_write_t  pending_writes[$];
    logic [25:0] crystal_cfg;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          error_count;
    int          quiet_cycles;

    clock_synth_frequency_planner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic push_write(input logic [7:0] addr, input logic [7:0] data);
        reg_write_t w;
        w.addr = addr;
        w.data = data;
        w.last = 1'b0;
        pending_writes.push_back(w);
    endtask

    task automatic push_block(input logic [7:0] base, input logic [31:0] p1,
                              input logic [31:0] p2, input logic [31:0] p3,
                              input logic [7:0] rbits);
        push_write(base,        p3[15:8]);
        push_write(base + 8'd1, p3[7:0]);
        push_write(base + 8'd2, {6'd0, p1[17:16]} | rbits);
        push_write(base + 8'd3, p1[15:8]);
        push_write(base + 8'd4, p1[7:0]);
        push_write(base + 8'd5, {p3[19:16], p2[19:16]});
        push_write(base + 8'd6, p2[15:8]);
        push_write(base + 8'd7, p2[7:0]);
    endtask

    task automatic plan_writes(input logic chan_b, input logic [27:0] freq_in);
        logic [31:0] f;
        logic [31:0] xtal;
        logic [31:0] rdiv;
        logic [31:0] divider;
        logic [31:0] pll;
        logic [31:0] mult;
        logic [31:0] rem;
        logic [31:0] num;
        logic [31:0] t;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [63:0] wide;
        logic [7:0]  ctrl_reg;
        reg_write_t  w;
        ctrl_reg = chan_b ? 8'd18 : 8'd16;
        f = {4'd0, freq_in};
        if (f == 0)
        begin
            w.addr = ctrl_reg;
            w.data = 8'h80;
            w.last = 1'b1;
            pending_writes.push_back(w);
        end
        else
        begin
            if (f < 32'd7813)
                f = 32'd7813;
            if (f > 32'd225000000)
                f = 32'd225000000;
            xtal = (crystal_cfg < 26'd10000000) ? 32'd10000000 : {6'd0, crystal_cfg};
            rdiv = 0;
            while (chan_b ? (f <= 32'd1000000) : (f < 32'd1000000))
            begin
                f = f * 2;
                rdiv = rdiv + 32'h10;
            end
            divider = 32'd900000000 / f;
            if (divider[0])
                divider = divider - 1;
            pll = divider * f;
            mult = (pll / xtal) & 32'hFF;
            rem = pll % xtal;
            wide = {32'd0, rem} * 64'd1048575 / {32'd0, xtal};
            num = wide[31:0];
            t = (32'd128 * num) / 32'd1048575;
            p1 = 32'd128 * mult + t - 32'd512;
            p2 = 32'd128 * num - 32'd1048575 * t;
            push_block(chan_b ? 8'd34 : 8'd26, p1, p2, 32'd1048575, 8'd0);
            p1 = 32'd128 * divider - 32'd512;
            push_block(chan_b ? 8'd58 : 8'd42, p1, 32'd0, 32'd1, rdiv[7:0]);
            push_write(csfp_pkg::PllResetReg, chan_b ? 8'h80 : 8'h20);
            w.addr = ctrl_reg;
            w.data = chan_b ? 8'h6C : 8'h4F;
            w.last = 1'b1;
            pending_writes.push_back(w);
        end
    endtask

    task automatic send_request(input logic chan_b, input logic [27:0] freq);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, freq, chan_b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        plan_writes(chan_b, freq);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (250)
            @(negedge clk);
    endtask

    task automatic write_crystal(input logic [25:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        crystal_cfg = value;
    endtask

    always @(posedge clk)
    begin
        reg_write_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_writes.size() == 0)
                report_mismatch($sformatf("unexpected write %h", m_tdata));
            else
            begin
                w = pending_writes.pop_front();
                if (m_tdata[7:0] !== w.addr)
                    report_mismatch($sformatf("address %0d, expected %0d",
                                              m_tdata[7:0], w.addr));
                if (m_tdata[15:8] !== w.data)
                    report_mismatch($sformatf("data %h at %0d, expected %h",
                                              m_tdata[15:8], w.addr, w.data));
                if (m_tlast !== w.last)
                    report_mismatch($sformatf("last %b at %0d, expected %b",
                                              m_tlast, w.addr, w.last));
            end
        end
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("clock_synth_frequency_planner_test failed");
            $finish;
        end
    end

    task automatic test_directed();
        logic [27:0] corner[12];
        corner = '{28'd0, 28'd1, 28'd7812, 28'd7813, 28'd999999, 28'd1000000,
                   28'd1000001, 28'd225000000, 28'd225000001, 28'hFFFFFFF,
                   28'd14318180, 28'h5555555};
        foreach (corner[i])
        begin
            send_request(1'b0, corner[i]);
            send_request(1'b1, corner[i]);
        end
    endtask

    task automatic test_random(input int count);
        logic [27:0] f;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(5))
                0: f = 28'($urandom_range(1000));
                1: f = 28'($urandom_range(1100000, 900000));
                2: f = 28'($urandom);
                3: f = 28'($urandom_range(225000000, 1));
                default: f = 28'($urandom_range(20000000, 7000));
            endcase
            send_request(1'($urandom_range(1)), f);
        end
    endtask

    task automatic test_crystals();
        logic [25:0] values[6];
        values = '{26'd10000000, 26'd40000000, 26'd0, 26'h3FFFFFF, 26'd9999999, 26'd25000000};
        foreach (values[i])
        begin
            write_crystal(values[i]);
            test_random(10);
        end
        write_crystal(26'($urandom_range(40000000, 10000000)));
    endtask

    task automatic test_full_pause();
        send_request(1'b1, 28'd48000000);
        wait_drained();
        send_request(1'b0, 28'd12345);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        error_count = 0;
        crystal_cfg = csfp_pkg::XtalReset;
        send_idle_pct = 33;
        recv_idle_pct = 47;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(90);
        send_idle_pct = 47;
        recv_idle_pct = 33;
        test_crystals();
        test_full_pause();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(184);
        wait_drained();
        if (error_count == 0)
            $display("clock_synth_frequency_planner_test passed");
        else
            $display("clock_synth_frequency_planner_test failed");
        $finish;
    end
endmodule
